// ===== rtl/jhtb_pkg.sv =====
`default_nettype none

package jhtb_pkg;

    localparam int MAX_CODE_BITS = 16;
    localparam int CODE_W        = MAX_CODE_BITS + 1;
    localparam int IDX_W         = $clog2(MAX_CODE_BITS);
    localparam int LEN_W         = IDX_W + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_CLASS,
        PH_COUNTS,
        PH_SYMBOLS
    } phase_t;

    typedef logic [7:0] count_t;

endpackage

`default_nettype wire

// ===== rtl/jpeg_huffman_table_builder.sv =====
`default_nettype none

// Builds canonical JPEG Huffman codes from the payload of a define-Huffman-table
// segment, one byte per transfer, and returns one result per symbol byte with its
// class, id, code, length and symbol. A byte is taken into an input register and its
// result is written to an output register at the next edge at which that register is
// free. With no back-pressure the block takes one byte every cycle; each byte passes
// through the input register and then its result through the output register. The
// search for the next nonzero count across the sixteen length counts is combinational.
// A result held by m_ready low holds the byte behind it and stalls the input.
// Assert s_segment_start on the first length byte; bytes outside a segment
// and all bytes after a code overflow are dropped until the next segment start.
module jpeg_huffman_table_builder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_segment_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_table_class,
    output logic [3:0]       m_table_id,
    output logic [15:0]      m_code_word,
    output logic [4:0]       m_code_length,
    output logic [7:0]       m_symbol_value,
    output logic             m_table_last,
    output logic             m_bad_table
);

    localparam int NB  = jhtb_pkg::MAX_CODE_BITS;
    localparam int CW  = jhtb_pkg::CODE_W;
    localparam int IW  = jhtb_pkg::IDX_W;
    localparam int LW  = jhtb_pkg::LEN_W;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;

    jhtb_pkg::phase_t       phase_reg, phase_next;
    logic [15:0]            bytes_left_reg, bytes_left_next;
    jhtb_pkg::count_t       counts_reg [NB];
    logic [NB-1:0]          nz_reg, nz_next;
    logic [IW-1:0]          count_index_reg, count_index_next;
    logic [LW-1:0]          cur_len_reg, cur_len_next;
    logic [7:0]             left_reg, left_next;
    logic [CW-1:0]          next_code_reg, next_code_next;
    logic [3:0]             class_reg, class_next;
    logic [3:0]             id_reg, id_next;
    logic [7:0]             len_high_reg, len_high_next;

    logic                   m_valid_reg;
    logic [3:0]             m_class_reg;
    logic [3:0]             m_id_reg;
    logic [15:0]            m_code_reg;
    logic [4:0]             m_len_reg;
    logic [7:0]             m_symbol_reg;
    logic                   m_last_reg;
    logic                   m_bad_reg;

    logic                   advance;
    logic                   emit;
    logic                   last_flag;
    logic                   bad_flag;
    logic                   counts_done;
    logic [15:0]            seg_len;
    logic [15:0]            seg_left;
    logic [15:0]            bytes_dec;
    logic [CW-1:0]          code_inc;
    logic [7:0]             left_dec;
    logic                   length_done;
    logic                   overflow;
    logic [NB-1:0]          nz_eff;
    logic [LW-1:0]          seek_start;
    logic                   seek_found;
    logic [IW-1:0]          seek_idx;
    jhtb_pkg::count_t       seek_count;
    logic [LW-1:0]          seek_len;
    logic [LW-1:0]          shift_amt;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign seg_len     = {len_high_reg, in_byte_reg};
    assign seg_left    = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
    assign bytes_dec   = bytes_left_reg - {15'd0, (bytes_left_reg != 16'd0)};
    assign counts_done = (count_index_reg == IW'(NB - 1));

    assign code_inc    = next_code_reg + CW'(1);
    assign left_dec    = left_reg - {7'd0, (left_reg != 8'd0)};
    assign length_done = (left_dec == 8'd0);
    assign overflow    = ((code_inc >> cur_len_reg) != '0);

    assign nz_eff     = (phase_reg == jhtb_pkg::PH_COUNTS)
                      ? {(in_byte_reg != 8'd0), nz_reg[NB-2:0]} : nz_reg;
    assign seek_start = (phase_reg == jhtb_pkg::PH_COUNTS) ? '0 : cur_len_reg;

    always_comb begin
        seek_found = 1'b0;
        seek_idx   = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (nz_eff[i] && (LW'(i) >= seek_start)) begin
                seek_found = 1'b1;
                seek_idx   = IW'(i);
            end
        end
    end

    assign seek_count = ((phase_reg == jhtb_pkg::PH_COUNTS) && (seek_idx == IW'(NB - 1)))
                      ? in_byte_reg : counts_reg[seek_idx];
    assign seek_len   = LW'(seek_idx) + LW'(1);
    assign shift_amt  = seek_len - cur_len_reg;

    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            if (in_start_reg) begin
                phase_next = jhtb_pkg::PH_LEN_LO;
            end else begin
                unique case (phase_reg)
                    jhtb_pkg::PH_IDLE: begin
                        phase_next = jhtb_pkg::PH_IDLE;
                    end
                    jhtb_pkg::PH_LEN_LO: begin
                        phase_next = (seg_left == 16'd0) ? jhtb_pkg::PH_IDLE
                                                          : jhtb_pkg::PH_CLASS;
                    end
                    jhtb_pkg::PH_CLASS: begin
                        phase_next = jhtb_pkg::PH_COUNTS;
                    end
                    jhtb_pkg::PH_COUNTS: begin
                        if (counts_done) begin
                            if (seek_found) begin
                                phase_next = jhtb_pkg::PH_SYMBOLS;
                            end else begin
                                phase_next = (bytes_dec == 16'd0) ? jhtb_pkg::PH_IDLE
                                                                  : jhtb_pkg::PH_CLASS;
                            end
                        end
                    end
                    jhtb_pkg::PH_SYMBOLS: begin
                        if (length_done) begin
                            if (overflow) begin
                                phase_next = jhtb_pkg::PH_IDLE;
                            end else if (!seek_found) begin
                                phase_next = (bytes_dec == 16'd0) ? jhtb_pkg::PH_IDLE
                                                                  : jhtb_pkg::PH_CLASS;
                            end
                        end
                    end
                    default: begin
                        phase_next = jhtb_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        bytes_left_next  = bytes_left_reg;
        nz_next          = nz_reg;
        count_index_next = count_index_reg;
        cur_len_next     = cur_len_reg;
        left_next        = left_reg;
        next_code_next   = next_code_reg;
        class_next       = class_reg;
        id_next          = id_reg;
        len_high_next    = len_high_reg;
        emit             = 1'b0;
        last_flag        = 1'b0;
        bad_flag         = 1'b0;
        if (advance) begin
            if (in_start_reg) begin
                len_high_next = in_byte_reg;
            end else begin
                unique case (phase_reg)
                    jhtb_pkg::PH_LEN_LO: begin
                        bytes_left_next = seg_left;
                    end
                    jhtb_pkg::PH_CLASS: begin
                        bytes_left_next  = bytes_dec;
                        class_next       = in_byte_reg[7:4];
                        id_next          = in_byte_reg[3:0];
                        count_index_next = '0;
                    end
                    jhtb_pkg::PH_COUNTS: begin
                        bytes_left_next           = bytes_dec;
                        nz_next[count_index_reg]  = (in_byte_reg != 8'd0);
                        count_index_next          = count_index_reg + IW'(1);
                        if (counts_done) begin
                            count_index_next = '0;
                            next_code_next   = '0;
                            if (seek_found) begin
                                cur_len_next = seek_len;
                                left_next    = seek_count;
                            end else begin
                                cur_len_next = LW'(NB);
                                left_next    = 8'd0;
                            end
                        end
                    end
                    jhtb_pkg::PH_SYMBOLS: begin
                        bytes_left_next = bytes_dec;
                        emit            = 1'b1;
                        next_code_next  = code_inc;
                        left_next       = left_dec;
                        if (length_done) begin
                            if (overflow) begin
                                bad_flag  = 1'b1;
                                last_flag = 1'b1;
                            end else if (seek_found) begin
                                cur_len_next   = seek_len;
                                left_next      = seek_count;
                                next_code_next = code_inc << shift_amt;
                            end else begin
                                last_flag    = 1'b1;
                                cur_len_next = LW'(NB);
                            end
                        end
                    end
                    default: begin
                        bytes_left_next = bytes_left_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            phase_reg       <= jhtb_pkg::PH_IDLE;
            bytes_left_reg  <= '0;
            nz_reg          <= '0;
            count_index_reg <= '0;
            cur_len_reg     <= '0;
            left_reg        <= '0;
            next_code_reg   <= '0;
            class_reg       <= '0;
            id_reg          <= '0;
            len_high_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            nz_reg          <= nz_next;
            count_index_reg <= count_index_next;
            cur_len_reg     <= cur_len_next;
            left_reg        <= left_next;
            next_code_reg   <= next_code_next;
            class_reg       <= class_next;
            id_reg          <= id_next;
            len_high_reg    <= len_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_segment_start;
        end
        if (advance && !in_start_reg && (phase_reg == jhtb_pkg::PH_COUNTS)) begin
            counts_reg[count_index_reg] <= in_byte_reg;
        end
        if (advance && emit) begin
            m_class_reg  <= class_reg;
            m_id_reg     <= id_reg;
            m_code_reg   <= next_code_reg[15:0];
            m_len_reg    <= cur_len_reg;
            m_symbol_reg <= in_byte_reg;
            m_last_reg   <= last_flag;
            m_bad_reg    <= bad_flag;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_table_class  = m_class_reg;
    assign m_table_id     = m_id_reg;
    assign m_code_word    = m_code_reg;
    assign m_code_length  = m_len_reg;
    assign m_symbol_value = m_symbol_reg;
    assign m_table_last   = m_last_reg;
    assign m_bad_table    = m_bad_reg;

`ifndef NO_ASSERTIONS
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_bad_reg || m_last_reg))
        else $error("bad table result without table end");

    a_bad_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && bad_flag) |=> (phase_reg == jhtb_pkg::PH_IDLE))
        else $error("code overflow did not drop the segment");

    a_symbols_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == jhtb_pkg::PH_SYMBOLS) |-> (left_reg != 8'd0))
        else $error("symbol phase with no symbols left at this length");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_len_reg != 5'd0) && (m_len_reg <= 5'(NB))))
        else $error("code length out of range");
`endif

endmodule

`default_nettype wire
